[hdl/c2cs_pkg.sv]
// ----------------------------------------------------------------------------
// c2cs_pkg: shared types and constants for the coordinate converter
// Holds the arctangent table, the pipeline widths and the cordic lane struct.
// ----------------------------------------------------------------------------
`default_nettype none

package c2cs_pkg;

  localparam int COORD_BITS   = 16;
  localparam int ANGLE_FRAC   = 13;
  localparam int ACC_FRAC     = 30;
  localparam int STEPS        = 31;
  localparam int W            = 62;   // cordic datapath width
  localparam int ZW           = 34;   // q30 accumulator width (signed)
  localparam int SQW          = 34;   // squared magnitudes
  localparam int RW           = 18;   // root width
  localparam int SQ_NB        = 72;   // square root radicand bits, even
  localparam int SQ_LAT       = 36;   // square root stages, SQ_NB/2
  localparam int LATENCY      = 73;   // start edge to result edge

  localparam logic [ZW-1:0] PI_Q30      = 34'd3373259426;
  localparam logic [ZW-1:0] HALF_PI_Q30 = 34'd1686629713;

  function automatic logic [ZW-1:0] atan_tab(input logic [4:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0: v = 34'd843314857;
      5'd1: v = 34'd497837829;
      5'd2: v = 34'd263043837;
      5'd3: v = 34'd133525159;
      5'd4: v = 34'd67021687;
      5'd5: v = 34'd33543516;
      5'd6: v = 34'd16775851;
      5'd7: v = 34'd8388437;
      5'd8: v = 34'd4194283;
      5'd9: v = 34'd2097149;
      default: v = ZW'(34'd1) << (ACC_FRAC - 10 - (int'(i) - 10));
    endcase
    return v;
  endfunction

  // one cordic lane in flight
  typedef struct packed {
    logic signed [W:0]  x;
    logic signed [W:0]  y;
    logic signed [ZW:0] z;
    logic               trivial;   // angle is fixed, cordic ignored
    logic [ZW-1:0]      fixed;
    logic               xneg;
    logic               yneg;
  } lane_t;

endpackage

`default_nettype wire

[hdl/cartesian_to_cyl_sph_converter_core.sv]
// ----------------------------------------------------------------------------
// cartesian_to_cyl_sph_converter_core: cartesian to cylindrical/spherical
// throughput: one request per cycle, busy stays low; the 31-stage
// cordic and the bit-per-stage square roots set the depth
// reset: synchronous rst clears every valid bit, no request is in flight
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_cyl_sph_converter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        mode,
  input  wire logic signed [15:0] coord_x,
  input  wire logic signed [15:0] coord_y,
  input  wire logic signed [15:0] coord_z,
  output      logic        done,
  output      logic [15:0] radius,
  output      logic signed [15:0] azimuth,
  output      logic signed [15:0] height,
  output      logic [14:0] polar,
  output      logic        zero_radius
);
  import c2cs_pkg::*;

  localparam int TOT = LATENCY;

  assign busy = 1'b0;

  // stage 1: magnitudes
  logic        v1, m1;
  logic [15:0] ux1, uy1, uz1;
  logic        xn1, yn1, zn1;
  logic signed [15:0] z1;
  always_ff @(posedge clk) begin
    ux1 <= coord_x[15] ? 16'(-coord_x) : 16'(coord_x);
    uy1 <= coord_y[15] ? 16'(-coord_y) : 16'(coord_y);
    uz1 <= coord_z[15] ? 16'(-coord_z) : 16'(coord_z);
    xn1 <= coord_x[15]; yn1 <= coord_y[15]; zn1 <= coord_z[15];
    m1  <= mode; z1 <= coord_z;
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
  end

  // stage 2: squares
  logic        v2, m2, xn2, yn2, zn2;
  logic [15:0] ux2, uy2, uz2;
  logic [31:0] xx2, yy2, zz2;
  logic signed [15:0] z2;
  always_ff @(posedge clk) begin
    xx2 <= ux1 * ux1; yy2 <= uy1 * uy1; zz2 <= uz1 * uz1;
    ux2 <= ux1; uy2 <= uy1; uz2 <= uz1;
    xn2 <= xn1; yn2 <= yn1; zn2 <= zn1; m2 <= m1; z2 <= z1;
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  // stage 3: sums
  logic        v3, m3, xn3, yn3, zn3, tz3;
  logic [15:0] ux3, uy3;
  logic [33:0] sxy3, tot3, sz3;
  logic signed [15:0] z3;
  always_ff @(posedge clk) begin
    sxy3 <= 34'(xx2) + 34'(yy2);
    sz3  <= 34'(zz2);
    tot3 <= 34'(xx2) + 34'(yy2) + 34'(zz2);
    tz3  <= (ux2 == '0) && (uy2 == '0) && (uz2 == '0);
    ux3 <= ux2; uy3 <= uy2;
    xn3 <= xn2; yn3 <= yn2; zn3 <= zn2; m3 <= m2; z3 <= z2;
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  // square roots: radius radicand and the polar rho
  logic [33:0] rad_sel;
  assign rad_sel = m3 ? sxy3 : tot3;
  logic [35:0] r_root;
  logic [37:0] r_rem;
  c2cs_sqrt u_rad (
    .clk(clk), .rad({38'd0, rad_sel}), .root(r_root), .rem(r_rem)
  );

  // polar pre-shift: sxy and sz go up by 2k so the larger one reaches
  // bit 62 or 63, z goes up by k; k runs from 16 to 31
  logic [33:0] mor;
  logic [5:0]  msb3;
  logic [4:0]  k3;
  logic [63:0] rho_rad;
  always_comb begin
    mor  = sxy3 | sz3;
    msb3 = 6'd0;
    for (int b = 0; b < 34; b++) begin
      if (mor[b]) msb3 = 6'(b);
    end
    k3 = 5'(6'd31 - {1'b0, msb3[5:1]});
  end
  assign rho_rad = {30'd0, sxy3} << {k3, 1'b0};

  logic [35:0] rho_root;
  logic [37:0] rho_rem;
  c2cs_sqrt u_rho (
    .clk(clk), .rad({8'd0, rho_rad}), .root(rho_root), .rem(rho_rem)
  );

  // delay lines to align with the roots
  localparam int DL = 36;
  logic [15:0] uxd [0:DL], uyd [0:DL];
  logic [15:0] uzd [0:DL];
  logic [4:0]  kd  [0:DL];
  logic        xnd [0:DL], ynd [0:DL], znd [0:DL], md [0:DL], tzd [0:DL];
  logic signed [15:0] zd [0:DL];
  logic        vd  [0:DL];
  assign uxd[0] = ux3; assign uyd[0] = uy3; assign uzd[0] = sz3[15:0];
  assign xnd[0] = xn3; assign ynd[0] = yn3; assign znd[0] = zn3;
  assign md[0] = m3; assign tzd[0] = tz3; assign zd[0] = z3; assign vd[0] = v3;
  assign kd[0] = k3;
  for (genvar g = 0; g < DL; g++) begin : g_dl
    always_ff @(posedge clk) begin
      uxd[g+1] <= uxd[g]; uyd[g+1] <= uyd[g];
      uzd[g+1] <= (g == 0) ? (zd[g][15] ? 16'(-zd[g]) : 16'(zd[g])) : uzd[g];
      kd[g+1] <= kd[g];
      xnd[g+1] <= xnd[g]; ynd[g+1] <= ynd[g]; znd[g+1] <= znd[g];
      md[g+1] <= md[g]; tzd[g+1] <= tzd[g]; zd[g+1] <= zd[g];
      if (rst) vd[g+1] <= 1'b0;
      else     vd[g+1] <= vd[g];
    end
  end

  // radius rounding, aligned with the side path
  logic [15:0] rad_r;
  always_ff @(posedge clk) begin
    rad_r <= 16'((r_rem > 38'(r_root)) ? r_root + 36'd1 : r_root);
  end

  // scaled z, below 2^32
  logic [35:0] zs_d;
  assign zs_d = 36'(uzd[DL]) << kd[DL];

  // cordic lanes: azimuth from (x,y), polar from (zs, rho)
  lane_t az_lane, po_lane;
  c2cs_norm u_naz (
    .clk(clk), .ax({20'd0, uxd[DL]}), .ay({20'd0, uyd[DL]}),
    .xneg(xnd[DL]), .yneg(ynd[DL]), .lane(az_lane)
  );
  c2cs_norm u_npo (
    .clk(clk), .ax(zs_d), .ay(rho_root),
    .xneg(znd[DL]), .yneg(1'b0), .lane(po_lane)
  );

  logic v_n, m_n, tz_n;
  logic signed [15:0] z_n;
  always_ff @(posedge clk) begin
    m_n <= md[DL]; tz_n <= tzd[DL]; z_n <= zd[DL];
    if (rst) v_n <= 1'b0;
    else     v_n <= vd[DL];
  end

  logic az_v, po_v;
  logic signed [15:0] az_a, po_a;
  c2cs_cordic u_caz (
    .clk(clk), .rst(rst), .in_valid(v_n), .lane_in(az_lane),
    .out_valid(az_v), .angle(az_a)
  );
  c2cs_cordic u_cpo (
    .clk(clk), .rst(rst), .in_valid(v_n), .lane_in(po_lane),
    .out_valid(po_v), .angle(po_a)
  );

  // side info delayed across the cordic
  logic m_c [0:32], tz_c [0:32];
  logic signed [15:0] z_c [0:32];
  assign m_c[0] = m_n; assign tz_c[0] = tz_n; assign z_c[0] = z_n;
  for (genvar g = 0; g < 32; g++) begin : g_cd
    always_ff @(posedge clk) begin
      m_c[g+1] <= m_c[g]; tz_c[g+1] <= tz_c[g]; z_c[g+1] <= z_c[g];
    end
  end

  // radius path: stages 1 to 3, the square root and rad_r match the side path, then across the cordic
  logic [15:0] rad_x [0:32];
  assign rad_x[0] = rad_r;
  for (genvar g = 0; g < 32; g++) begin : g_rx
    always_ff @(posedge clk) rad_x[g+1] <= rad_x[g];
  end

  always_ff @(posedge clk) begin
    radius      <= rad_x[32];
    azimuth     <= az_a;
    height      <= m_c[32] ? z_c[32] : 16'sd0;
    polar       <= (m_c[32] || tz_c[32]) ? 15'd0 : 15'(po_a);
    zero_radius <= !m_c[32] && tz_c[32];
    if (rst) done <= 1'b0;
    else     done <= az_v && po_v;
  end

  logic unused_ok;
  assign unused_ok = ^{rho_rem, TOT, sz3[33:16]};
endmodule

`default_nettype wire

[hdl/c2cs_sqrt.sv]
// ----------------------------------------------------------------------------
// c2cs_sqrt: pipelined restoring square root
// One result bit per stage, with the remainder kept for rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module c2cs_sqrt (
  input  wire logic                            clk,
  input  wire logic [c2cs_pkg::SQ_NB-1:0]      rad,
  output      logic [c2cs_pkg::SQ_NB/2-1:0]    root,
  output      logic [c2cs_pkg::SQ_NB/2+1:0]    rem
);
  import c2cs_pkg::*;

  logic [SQ_NB-1:0]   op  [0:SQ_LAT];
  logic [SQ_NB/2-1:0] res [0:SQ_LAT];
  logic [SQ_NB/2+1:0] rr  [0:SQ_LAT];

  assign op[0]  = rad;
  assign res[0] = '0;
  assign rr[0]  = '0;

  for (genvar g = 0; g < SQ_LAT; g++) begin : g_st
    logic [SQ_NB/2+1:0] trial;
    logic [SQ_NB/2+1:0] cand;
    always_comb begin
      trial = {rr[g][SQ_NB/2-1:0], op[g][SQ_NB-1 -: 2]};
      cand  = {res[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      op[g+1] <= op[g] << 2;
      if (trial >= cand) begin
        rr[g+1]  <= trial - cand;
        res[g+1] <= {res[g][SQ_NB/2-2:0], 1'b1};
      end else begin
        rr[g+1]  <= trial;
        res[g+1] <= {res[g][SQ_NB/2-2:0], 1'b0};
      end
    end
  end

  assign root = res[SQ_LAT];
  assign rem  = rr[SQ_LAT];
endmodule

`default_nettype wire

[hdl/c2cs_cordic.sv]
// ----------------------------------------------------------------------------
// c2cs_cordic: pipelined vectoring cordic, atan2 with rounding
// One micro-rotation per stage, then quadrant fix-up and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module c2cs_cordic (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire c2cs_pkg::lane_t        lane_in,
  output      logic                   out_valid,
  output      logic signed [15:0]     angle
);
  import c2cs_pkg::*;

  lane_t ln [0:STEPS];
  logic  vl [0:STEPS];

  assign ln[0] = lane_in;
  assign vl[0] = in_valid;

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    lane_t nx;
    always_comb begin
      nx = ln[i];
      if (ln[i].y > 0) begin
        nx.x = ln[i].x + (ln[i].y >>> i);
        nx.y = ln[i].y - (ln[i].x >>> i);
        nx.z = ln[i].z + $signed({1'b0, atan_tab(5'(i))});
      end else begin
        nx.x = ln[i].x - (ln[i].y >>> i);
        nx.y = ln[i].y + (ln[i].x >>> i);
        nx.z = ln[i].z - $signed({1'b0, atan_tab(5'(i))});
      end
    end
    always_ff @(posedge clk) begin
      ln[i+1] <= nx;
      if (rst) vl[i+1] <= 1'b0;
      else     vl[i+1] <= vl[i];
    end
  end

  // clamp, quadrant, round
  lane_t           f;
  logic [ZW-1:0]   q, a, mag;
  logic [ZW-ACC_FRAC+ANGLE_FRAC:0] rnd;
  always_comb begin
    f = ln[STEPS];
    if (f.trivial)                        q = f.fixed;
    else if (f.z < 0)                     q = '0;
    else if (f.z > $signed({1'b0, HALF_PI_Q30})) q = HALF_PI_Q30;
    else                                  q = f.z[ZW-1:0];
    a   = f.xneg ? PI_Q30 - q : q;
    mag = a + (ZW'(1) << (ACC_FRAC - ANGLE_FRAC - 1));
    rnd = (ZW-ACC_FRAC+ANGLE_FRAC+1)'(mag >> (ACC_FRAC - ANGLE_FRAC));
  end

  always_ff @(posedge clk) begin
    angle <= f.yneg ? -$signed(16'(rnd)) : $signed(16'(rnd));
    if (rst) out_valid <= 1'b0;
    else     out_valid <= vl[STEPS];
  end
endmodule

`default_nettype wire

[hdl/c2cs_norm.sv]
// ----------------------------------------------------------------------------
// c2cs_norm: normalizing front end of a cordic lane
// Registered leading-bit shift that lifts the larger magnitude to bit 59.
// ----------------------------------------------------------------------------
`default_nettype none

module c2cs_norm (
  input  wire logic             clk,
  input  wire logic [35:0]      ax,
  input  wire logic [35:0]      ay,
  input  wire logic             xneg,
  input  wire logic             yneg,
  output      c2cs_pkg::lane_t  lane
);
  import c2cs_pkg::*;

  logic [35:0] m;
  logic [5:0]  lz;
  lane_t       nl;
  always_comb begin
    m  = (ax > ay) ? ax : ay;
    lz = 6'd0;
    for (int b = 0; b < 36; b++) begin
      if (m[b]) lz = 6'(59 - b);
    end
    nl.x       = $signed({1'b0, W'({26'd0, ax} << lz)});
    nl.y       = $signed({1'b0, W'({26'd0, ay} << lz)});
    nl.z       = '0;
    nl.xneg    = xneg;
    nl.yneg    = yneg;
    nl.trivial = (ay == '0) || (ax == '0);
    nl.fixed   = (ay == '0) ? '0 : HALF_PI_Q30;
  end

  always_ff @(posedge clk) begin
    lane <= nl;
  end
endmodule

`default_nettype wire

[hdl/c2cs_check.sv]
// ----------------------------------------------------------------------------
// c2cs_check: port checker for the converter core
// Watches done timing and result ranges against accepted requests.
// ----------------------------------------------------------------------------
`default_nettype none

module c2cs_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [14:0] polar,
  input wire logic        zero_radius,
  input wire logic [15:0] radius,
  input wire logic signed [15:0] height
);
  import c2cs_pkg::*;

  a_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("done strobe missing for an accepted request");
  a_zr: assert property (@(posedge clk) disable iff (rst)
    done && zero_radius |-> radius == '0 && polar == '0)
    else $error("zero radius result not clean");
  a_ht: assert property (@(posedge clk) disable iff (rst)
    done && zero_radius |-> height == '0)
    else $error("height set in spherical mode");
  a_rng: assert property (@(posedge clk) disable iff (rst)
    done |-> polar <= 15'd25736)
    else $error("polar out of range");
endmodule

bind cartesian_to_cyl_sph_converter_core c2cs_check u_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .polar(polar), .zero_radius(zero_radius), .radius(radius), .height(height)
);

`default_nettype wire
